>>> hw/rtl/ascii_position_line_parser_unit_defines.svh
// ----------------------------------------------------------------------------
// ascii_position_line_parser_unit assertion macros
// Shared concurrent assertion forms, clocked on clk, quiet while in reset.
// ----------------------------------------------------------------------------
`ifndef ASCII_POSITION_LINE_PARSER_UNIT_DEFINES_SVH
`define ASCII_POSITION_LINE_PARSER_UNIT_DEFINES_SVH

// same-cycle implication
`define APLP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("aplp assertion failed");

// next-cycle implication
`define APLP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("aplp assertion failed");

`endif

>>> hw/rtl/aplp_pkg.sv
// ----------------------------------------------------------------------------
// aplp_pkg
// Types, constants and helpers of the ASCII position line parser.
// ----------------------------------------------------------------------------
package aplp_pkg;

    localparam int APLP_MAX_LINE    = 64;
    localparam int APLP_FRAC_DIGITS = 3;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [30:0] MAG_MAX       = 31'h7FFF_FFFF;
    localparam logic [15:0] TIMEOUT_RESET = 16'd500;
    localparam logic [30:0] LIMIT_RESET   = 31'd110000;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_P     = 8'h50;

    typedef enum logic [1:0] {
        KIND_BYTE     = 2'd0,
        KIND_TICK     = 2'd1,
        KIND_LINK_ERR = 2'd2,
        KIND_IDLE     = 2'd3
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TIMEOUT = 2'd0,
        CFG_LIMIT   = 2'd1
    } cfg_idx_t;

    typedef enum logic [3:0] {
        PH_LINE    = 4'd0,
        PH_AFTER_P = 4'd1,
        PH_S_LEAD  = 4'd2,
        PH_S_BODY  = 4'd3,
        PH_P1_LEAD = 4'd4,
        PH_P1_BODY = 4'd5,
        PH_P2_LEAD = 4'd6,
        PH_P2_BODY = 4'd7,
        PH_DONE_S  = 4'd8,
        PH_DONE_PT = 4'd9,
        PH_FAIL    = 4'd10
    } phase_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  data_byte;
        logic        end_of_frame;
    } item_t;

    typedef struct packed {
        logic        done;
        logic        ok;
        logic        carries_tgt;
        logic [31:0] pos_value;
        logic [31:0] tgt_value;
    } frame_evt_t;

    // decimal scale of one digit place
    function automatic logic [13:0] pow10(input logic [2:0] e);
        logic [13:0] r;
        case (e)
            3'd0:    r = 14'd1;
            3'd1:    r = 14'd10;
            3'd2:    r = 14'd100;
            3'd3:    r = 14'd1000;
            3'd4:    r = 14'd10000;
            default: r = 14'd1;
        endcase
        return r;
    endfunction

endpackage

>>> hw/rtl/aplp_if.sv
// ----------------------------------------------------------------------------
// aplp interfaces
// Valid/ready channels of the parser: input items, results, register writes.
// ----------------------------------------------------------------------------
interface aplp_item_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic       end_of_frame;

    modport source (output valid, kind, data_byte, end_of_frame, input ready);
    modport sink   (input valid, kind, data_byte, end_of_frame, output ready);
endinterface

interface aplp_result_if;
    logic               valid;
    logic               ready;
    logic               frame_done;
    logic               frame_ok;
    logic signed [31:0] position;
    logic signed [31:0] target;
    logic               position_valid;
    logic               connected;
    logic               target_seen;
    logic [31:0]        good_frames;
    logic [31:0]        target_frames;
    logic [31:0]        error_count;

    modport source (output valid, frame_done, frame_ok, position, target,
                    position_valid, connected, target_seen, good_frames,
                    target_frames, error_count, input ready);
    modport sink   (input valid, frame_done, frame_ok, position, target,
                    position_valid, connected, target_seen, good_frames,
                    target_frames, error_count, output ready);
endinterface

interface aplp_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> hw/rtl/aplp_in_stage.sv
// ----------------------------------------------------------------------------
// aplp_in_stage
// Input register: holds one item until the parse stage takes it.
// ----------------------------------------------------------------------------
module aplp_in_stage
    import aplp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    aplp_item_if.sink  item,
    input  logic       advance,
    output logic       stage_vld,
    output item_t      stage_item
);

    logic  vld_reg;
    logic  vld_next;
    item_t item_reg;
    logic  accept;

    assign item.ready = !vld_reg || advance;
    assign accept     = item.valid && item.ready;

    always_comb
    begin
        if (accept)
        begin
            vld_next = 1'b1;
        end
        else if (advance)
        begin
            vld_next = 1'b0;
        end
        else
        begin
            vld_next = vld_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.kind         <= kind_t'(item.kind);
            item_reg.data_byte    <= item.data_byte;
            item_reg.end_of_frame <= item.end_of_frame;
        end
    end

    assign stage_vld  = vld_reg;
    assign stage_item = item_reg;

endmodule

>>> hw/rtl/aplp_cfg_regs.sv
// ----------------------------------------------------------------------------
// aplp_cfg_regs
// Configuration registers: link timeout and target magnitude limit.
// ----------------------------------------------------------------------------
module aplp_cfg_regs
    import aplp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    aplp_cfg_if.sink    cfg,
    output logic [15:0] timeout_ticks,
    output logic [30:0] target_limit
);

    logic [15:0] timeout_reg;
    logic [15:0] timeout_next;
    logic [30:0] limit_reg;
    logic [30:0] limit_next;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        timeout_next = timeout_reg;
        limit_next   = limit_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_TIMEOUT: timeout_next = cfg.data[15:0];
                CFG_LIMIT:   limit_next   = cfg.data[30:0];
                default:     ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
            limit_reg   <= LIMIT_RESET;
        end
        else
        begin
            timeout_reg <= timeout_next;
            limit_reg   <= limit_next;
        end
    end

    assign timeout_ticks = timeout_reg;
    assign target_limit  = limit_reg;

endmodule

>>> hw/rtl/aplp_parser.sv
// ----------------------------------------------------------------------------
// aplp_parser
// Per-byte frame parser: phase, number accumulator and frame close logic.
// ----------------------------------------------------------------------------
module aplp_parser
    import aplp_pkg::*;
#(
    parameter int MAX_LINE    = APLP_MAX_LINE,
    parameter int FRAC_DIGITS = APLP_FRAC_DIGITS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  item_t       stage_item,
    input  logic [30:0] target_limit,
    output frame_evt_t  evt
);

    localparam int BC_W = $clog2(MAX_LINE + 1);
    localparam int PL_W = $clog2(FRAC_DIGITS + 1);

    phase_t            phase_reg,  phase_next;
    logic [30:0]       acc_reg,    acc_next;
    logic              neg_reg,    neg_next;
    logic              saw_reg,    saw_next;
    logic              frac_reg,   frac_next;
    logic [PL_W-1:0]   place_reg,  place_next;
    logic [31:0]       first_reg,  first_next;
    logic [BC_W-1:0]   bc_reg,     bc_next;

    always_comb
    begin
        phase_t          ph;
        phase_t          body_ph;
        logic [30:0]     acc;
        logic            neg;
        logic            saw;
        logic            frac;
        logic [PL_W-1:0] place;
        logic [31:0]     first;
        logic [BC_W-1:0] bc;
        logic            do_body;
        logic            is_space;
        logic            is_term;
        logic            is_digit;
        logic [7:0]      c;
        logic [17:0]     dsc;
        logic [35:0]     v;
        logic            take;
        logic [31:0]     sval;
        logic [1:0]      res;

        ph      = phase_reg;
        acc     = acc_reg;
        neg     = neg_reg;
        saw     = saw_reg;
        frac    = frac_reg;
        place   = place_reg;
        first   = first_reg;
        bc      = bc_reg;
        do_body = 1'b0;
        body_ph = PH_S_BODY;
        c       = stage_item.data_byte;
        dsc     = '0;
        v       = '0;
        take    = 1'b0;
        sval    = '0;
        res     = 2'd0;
        evt     = '0;

        is_space = (c == CH_SPACE) || (c == CH_TAB);
        is_term  = (c == CH_COMMA) || (c == CH_CR) || (c == CH_LF);
        is_digit = (c >= CH_ZERO) && (c <= CH_NINE);

        case (stage_item.kind)
            KIND_BYTE:
            begin
                bc = bc_reg + BC_W'(1);

                case (phase_reg)
                    PH_P1_LEAD: body_ph = PH_P1_BODY;
                    PH_P2_LEAD: body_ph = PH_P2_BODY;
                    default:    body_ph = PH_S_BODY;
                endcase

                case (phase_reg)
                    PH_LINE, PH_S_LEAD, PH_P1_LEAD, PH_P2_LEAD:
                    begin
                        if (!is_space)
                        begin
                            if ((phase_reg == PH_LINE) && (c == CH_P))
                            begin
                                ph = PH_AFTER_P;
                            end
                            else
                            begin
                                ph = body_ph;
                                if (c == CH_MINUS)
                                begin
                                    neg = 1'b1;
                                end
                                else if (c != CH_PLUS)
                                begin
                                    do_body = 1'b1;
                                end
                            end
                        end
                    end
                    PH_AFTER_P: ph = (c == CH_COMMA) ? PH_P1_LEAD : PH_FAIL;
                    PH_S_BODY, PH_P1_BODY, PH_P2_BODY: do_body = 1'b1;
                    default: ;
                endcase

                if (do_body)
                begin
                    sval = neg ? (32'd0 - {1'b0, acc}) : {1'b0, acc};
                    if (is_term)
                    begin
                        if (!saw)
                        begin
                            ph = PH_FAIL;
                        end
                        else if (ph == PH_S_BODY)
                        begin
                            first = sval;
                            ph    = PH_DONE_S;
                        end
                        else if (ph == PH_P1_BODY)
                        begin
                            if (c == CH_COMMA)
                            begin
                                first = sval;
                                acc   = '0;
                                neg   = 1'b0;
                                saw   = 1'b0;
                                frac  = 1'b0;
                                place = '0;
                                ph    = PH_P2_LEAD;
                            end
                            else
                            begin
                                ph = PH_FAIL;
                            end
                        end
                        else
                        begin
                            ph = (acc <= target_limit) ? PH_DONE_PT : PH_FAIL;
                        end
                    end
                    else if (is_digit)
                    begin
                        saw = 1'b1;
                        if (!frac)
                        begin
                            dsc  = 18'(c[3:0]) * 18'(pow10(3'(FRAC_DIGITS)));
                            v    = ({5'd0, acc} << 3) + ({5'd0, acc} << 1) + 36'(dsc);
                            take = 1'b1;
                        end
                        else if (place < PL_W'(FRAC_DIGITS))
                        begin
                            dsc   = 18'(c[3:0])
                                  * 18'(pow10(3'(FRAC_DIGITS - 1) - 3'(place)));
                            v     = {5'd0, acc} + 36'(dsc);
                            place = place + PL_W'(1);
                            take  = 1'b1;
                        end
                        if (take)
                        begin
                            acc = (v > 36'(MAG_MAX)) ? MAG_MAX : v[30:0];
                        end
                    end
                    else if ((c == CH_DOT) && !frac)
                    begin
                        frac = 1'b1;
                    end
                    else
                    begin
                        ph = PH_FAIL;
                    end
                end

                if (stage_item.end_of_frame || (bc >= BC_W'(MAX_LINE)))
                begin
                    // frame close: 0 fail, 1 position only, 2 position and target
                    sval = neg ? (32'd0 - {1'b0, acc}) : {1'b0, acc};
                    case (ph)
                        PH_S_BODY:
                        begin
                            if (saw)
                            begin
                                first = sval;
                                res   = 2'd1;
                            end
                        end
                        PH_P2_BODY: res = (saw && (acc <= target_limit)) ? 2'd2 : 2'd0;
                        PH_DONE_S:  res = 2'd1;
                        PH_DONE_PT: res = 2'd2;
                        default:    res = 2'd0;
                    endcase
                    evt.done        = 1'b1;
                    evt.ok          = (res != 2'd0);
                    evt.carries_tgt = (res == 2'd2);
                    evt.pos_value   = first;
                    evt.tgt_value   = sval;
                    ph    = PH_LINE;
                    acc   = '0;
                    neg   = 1'b0;
                    saw   = 1'b0;
                    frac  = 1'b0;
                    place = '0;
                    first = '0;
                    bc    = '0;
                end
            end
            KIND_LINK_ERR:
            begin
                evt.done = (bc_reg != '0);
                ph    = PH_LINE;
                acc   = '0;
                neg   = 1'b0;
                saw   = 1'b0;
                frac  = 1'b0;
                place = '0;
                first = '0;
                bc    = '0;
            end
            default: ;
        endcase

        phase_next = ph;
        acc_next   = acc;
        neg_next   = neg;
        saw_next   = saw;
        frac_next  = frac;
        place_next = place;
        first_next = first;
        bc_next    = bc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_LINE;
            acc_reg   <= '0;
            neg_reg   <= 1'b0;
            saw_reg   <= 1'b0;
            frac_reg  <= 1'b0;
            place_reg <= '0;
            first_reg <= '0;
            bc_reg    <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            neg_reg   <= neg_next;
            saw_reg   <= saw_next;
            frac_reg  <= frac_next;
            place_reg <= place_next;
            first_reg <= first_next;
            bc_reg    <= bc_next;
        end
    end

endmodule

>>> hw/rtl/aplp_status.sv
// ----------------------------------------------------------------------------
// aplp_status
// Published values, link flags, counters and the result register.
// ----------------------------------------------------------------------------
module aplp_status
    import aplp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          step,
    input  kind_t         kind,
    input  frame_evt_t    evt,
    input  logic [15:0]   timeout_ticks,
    output logic          out_free,
    aplp_result_if.source result
);

    logic        out_vld_reg, out_vld_next;
    logic        done_reg,    done_next;
    logic        ok_reg,      ok_next;
    logic [31:0] pos_reg,     pos_next;
    logic [31:0] target_reg,  target_next;
    logic        valid_reg,   valid_next;
    logic        conn_reg,    conn_next;
    logic        tgt_reg,     tgt_next;
    logic [31:0] ok_cnt_reg,  ok_cnt_next;
    logic [31:0] tgt_cnt_reg, tgt_cnt_next;
    logic [31:0] err_cnt_reg, err_cnt_next;
    logic [15:0] idle_reg,    idle_next;

    // state only moves when the result register is free, so it doubles as payload
    assign out_free = !out_vld_reg || result.ready;

    always_comb
    begin
        out_vld_next = step ? 1'b1 : (result.ready ? 1'b0 : out_vld_reg);
        done_next    = evt.done;
        ok_next      = evt.ok;
        pos_next     = pos_reg;
        target_next  = target_reg;
        valid_next   = valid_reg;
        conn_next    = conn_reg;
        tgt_next     = tgt_reg;
        ok_cnt_next  = ok_cnt_reg;
        tgt_cnt_next = tgt_cnt_reg;
        err_cnt_next = err_cnt_reg;
        idle_next    = idle_reg;

        case (kind)
            KIND_BYTE:
            begin
                if (evt.done)
                begin
                    if (evt.ok)
                    begin
                        pos_next = evt.pos_value;
                        if (evt.carries_tgt)
                        begin
                            target_next  = evt.tgt_value;
                            tgt_next     = 1'b1;
                            tgt_cnt_next = tgt_cnt_reg + 32'd1;
                        end
                        valid_next  = 1'b1;
                        conn_next   = 1'b1;
                        idle_next   = '0;
                        ok_cnt_next = ok_cnt_reg + 32'd1;
                    end
                    else
                    begin
                        err_cnt_next = err_cnt_reg + 32'd1;
                    end
                end
            end
            KIND_TICK:
            begin
                if (idle_reg != 16'hFFFF)
                begin
                    idle_next = idle_reg + 16'd1;
                end
                if (conn_reg && (idle_next > timeout_ticks))
                begin
                    conn_next  = 1'b0;
                    valid_next = 1'b0;
                end
            end
            KIND_LINK_ERR: err_cnt_next = err_cnt_reg + 32'd1;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg    <= 1'b0;
            ok_reg      <= 1'b0;
            pos_reg     <= '0;
            target_reg  <= '0;
            valid_reg   <= 1'b0;
            conn_reg    <= 1'b0;
            tgt_reg     <= 1'b0;
            ok_cnt_reg  <= '0;
            tgt_cnt_reg <= '0;
            err_cnt_reg <= '0;
            idle_reg    <= '0;
        end
        else if (step)
        begin
            done_reg    <= done_next;
            ok_reg      <= ok_next;
            pos_reg     <= pos_next;
            target_reg  <= target_next;
            valid_reg   <= valid_next;
            conn_reg    <= conn_next;
            tgt_reg     <= tgt_next;
            ok_cnt_reg  <= ok_cnt_next;
            tgt_cnt_reg <= tgt_cnt_next;
            err_cnt_reg <= err_cnt_next;
            idle_reg    <= idle_next;
        end
    end

    assign result.valid          = out_vld_reg;
    assign result.frame_done     = done_reg;
    assign result.frame_ok       = ok_reg;
    assign result.position       = pos_reg;
    assign result.target         = target_reg;
    assign result.position_valid = valid_reg;
    assign result.connected      = conn_reg;
    assign result.target_seen    = tgt_reg;
    assign result.good_frames    = ok_cnt_reg;
    assign result.target_frames  = tgt_cnt_reg;
    assign result.error_count    = err_cnt_reg;

endmodule

>>> hw/rtl/ascii_position_line_parser_unit.sv
// ----------------------------------------------------------------------------
// ascii_position_line_parser_unit
// Parses "P,<pos>,<target>" or single decimal frames from a serial byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   item   : one received byte (with end-of-frame mark), one 1 ms tick or one
//            link error event per item.
//   result : exactly one result item per input item, carrying frame status,
//            the published position/target in thousandths, link flags and
//            the good/target/error counters.
//   cfg    : register writes (index 0 timeout in ticks, index 1 target limit);
//            always ready, write only while no item is in flight.
// The input register loads on the accepting edge; the result register loads
// when the held item advances, which waits while a result is still untaken.
// Throughput is one item per cycle while results are taken; the per-byte
// parse step fits between the registers and parser state feeds back per item.
// Reset clears the parser, flags and counters and loads the register defaults
// (timeout 500 ticks, limit 110000). When the result receiver stalls, the
// result holds, one further item waits in the input register, then item.ready
// drops.
// ----------------------------------------------------------------------------
module ascii_position_line_parser_unit
    import aplp_pkg::*;
#(
    parameter int MAX_LINE    = APLP_MAX_LINE,
    parameter int FRAC_DIGITS = APLP_FRAC_DIGITS
)
(
    input  logic          clk,
    input  logic          rst_n,
    aplp_item_if.sink     item,
    aplp_result_if.source result,
    aplp_cfg_if.sink      cfg
);

    logic        stage_vld;
    item_t       stage_item;
    logic        out_free;
    logic        advance;
    logic [15:0] timeout_ticks;
    logic [30:0] target_limit;
    frame_evt_t  evt;

    assign advance = stage_vld && out_free;

    aplp_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .advance    (advance),
        .stage_vld  (stage_vld),
        .stage_item (stage_item)
    );

    aplp_cfg_regs u_cfg_regs (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .timeout_ticks (timeout_ticks),
        .target_limit  (target_limit)
    );

    aplp_parser #(
        .MAX_LINE    (MAX_LINE),
        .FRAC_DIGITS (FRAC_DIGITS)
    ) u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (advance),
        .stage_item   (stage_item),
        .target_limit (target_limit),
        .evt          (evt)
    );

    aplp_status u_status (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (advance),
        .kind          (stage_item.kind),
        .evt           (evt),
        .timeout_ticks (timeout_ticks),
        .out_free      (out_free),
        .result        (result)
    );

`include "ascii_position_line_parser_unit_defines.svh"

    // a frame is only reported good when it closed
    `APLP_ASSERT_NOW(a_ok_needs_done, result.valid && result.frame_ok, result.frame_done)

    // a good frame always leaves the link connected with a fresh position
    `APLP_ASSERT_NOW(a_ok_sets_link, result.valid && result.frame_ok,
                     result.connected && result.position_valid)

    // position is never valid on a lost link
    `APLP_ASSERT_NOW(a_valid_needs_conn, result.position_valid, result.connected)

    // an accepted item is always held for the parse stage
    `APLP_ASSERT_NEXT(a_accept_fills_stage, item.valid && item.ready, stage_vld)

endmodule
